// ----- rtl/dhcpl_pkg.sv -----
// Shared types, codes and helpers for the DHCP lease table engine.
`default_nettype none

package dhcpl_pkg;

  // Table size default and address pool limits
  localparam int unsigned DEFAULT_LEASE_ENTRIES = 32;
  localparam logic [7:0]  POOL_LOW              = 8'd16;
  localparam logic [7:0]  POOL_HIGH             = 8'd254;
  localparam logic [7:0]  POOL_SIZE             = 8'd239;
  localparam logic [31:0] HOST_NET_MASK         = 32'hffff_ff00;

  // Message and reply type codes
  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;
  localparam logic [7:0] REPLY_NONE   = 8'd0;
  localparam logic [7:0] REPLY_OFFER  = 8'd2;
  localparam logic [7:0] REPLY_ACK    = 8'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_UNSUP = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Register map (index = byte address / 4) and reset values
  localparam logic REG_NETWORK = 1'b0;
  localparam logic REG_PREFIX  = 1'b1;
  localparam logic [31:0] NETWORK_RESET = 32'h0A00_0200;
  localparam logic [4:0]  PREFIX_RESET  = 5'd24;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MSCAN,
    S_HSCAN,
    S_WRITE,
    S_DONE
  } state_t;

  // Table write request
  typedef struct packed {
    logic        en;
    logic [47:0] mac;
    logic [31:0] addr;
  } tbl_wr_t;

  // Leased address from the network base and a host byte
  function automatic logic [31:0] host_addr(input logic [31:0] net, input logic [7:0] host);
    host_addr = (net & HOST_NET_MASK) | {24'd0, host};
  endfunction

  // Next host in the pool with wraparound
  function automatic logic [7:0] pool_next(input logic [7:0] host);
    pool_next = (host >= POOL_HIGH) ? POOL_LOW : host + 8'd1;
  endfunction

  // Force a host outside the pool back to its bottom
  function automatic logic [7:0] pool_clamp(input logic [7:0] host);
    pool_clamp = (host < POOL_LOW || host > POOL_HIGH) ? POOL_LOW : host;
  endfunction

  // Subnet mask from a prefix length
  function automatic logic [31:0] mask_of(input logic [4:0] p);
    logic [5:0] sh;
    sh = 6'd32 - {1'b0, p};
    mask_of = (p == 5'd0) ? 32'd0 : (32'hffff_ffff << sh);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dhcp_lease_table_engine_unit.sv -----
// DHCP lease table engine: request sequencer, config registers, result register.
//
//   channel | direction | handshake                        | beat
//   --------+-----------+----------------------------------+-------------------------------
//   in_     | input     | in_valid / in_ready              | MAC, message type, xid
//   out_    | output    | out_valid / out_ready            | status, reply, address, mask,
//           |           |                                  | xid, slot
//   cfg_    | APB slave | cfg_psel/cfg_penable, pready = 1 | network @0x0, prefix @0x4
//
// One request at a time. An unsupported type goes straight to S_DONE. A known MAC ends its
// scan at the match; a full table takes one pass over the table. A new lease adds up to one
// pass per host candidate tried (one more than the leased hosts skipped; a clash ends a pass
// early) plus the S_WRITE state; the single read port of the table sets this.
// Reset clears the valid bits, the next-host pointer (16) and both registers at once.
// A result waits in the output register; the next request is taken meanwhile and
// stalls only in its final state, S_DONE, until the previous result has gone.
`default_nettype none

module dhcp_lease_table_engine_unit
  import dhcpl_pkg::*;
#(
  parameter int unsigned LEASE_ENTRIES = DEFAULT_LEASE_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] in_client_mac,
  input  wire logic [7:0]  in_message_type,
  input  wire logic [31:0] in_transaction_id,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_reply_type,
  output logic [31:0]      out_leased_address,
  output logic [31:0]      out_subnet_mask,
  output logic [31:0]      out_echoed_transaction,
  output logic [4:0]       out_lease_slot,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned IDXW = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(LEASE_ENTRIES + 1);
  localparam logic [CNTW-1:0] ENTRY_CNT = CNTW'(LEASE_ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(LEASE_ENTRIES - 1);

  // Configuration registers
  logic [31:0] network_r;
  logic [4:0]  prefix_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      network_r <= NETWORK_RESET;
      prefix_r  <= PREFIX_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_NETWORK: network_r <= cfg_pwdata;
        REG_PREFIX:  prefix_r  <= cfg_pwdata[4:0];
        default:     network_r <= network_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_NETWORK: cfg_prdata = network_r;
      REG_PREFIX:  cfg_prdata = {27'd0, prefix_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Sequencer state
  state_t          state_r, state_nxt;
  logic [47:0]     mac_r, mac_nxt;
  logic [31:0]     xid_r, xid_nxt;
  logic [7:0]      reply_r, reply_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [IDXW-1:0] slot_r, slot_nxt;
  logic [IDXW-1:0] free_slot_r, free_slot_nxt;
  logic            free_found_r, free_found_nxt;
  logic [7:0]      host_r, host_nxt;
  logic [7:0]      tries_r, tries_nxt;
  logic [7:0]      next_host_r, next_host_nxt;
  logic [CNTW-1:0] rd_idx_r, rd_idx_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IDXW-1:0] cmp_idx_r, cmp_idx_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_reply_r, out_reply_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [31:0] out_mask_r, out_mask_nxt;
  logic [31:0] out_xid_r, out_xid_nxt;
  logic [4:0]  out_slot_r, out_slot_nxt;

  // Table interface
  logic            rd_en;
  tbl_wr_t         wr;
  logic            rd_valid;
  logic [47:0]     rd_mac;
  logic [31:0]     rd_addr;
  logic            last_cmp;
  logic [31:0]     cand_addr;
  logic [31:0]     slot_ext;

  dhcpl_tbl #(
    .LEASE_ENTRIES(LEASE_ENTRIES)
  ) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx_r[IDXW-1:0]),
    .wr       (wr),
    .wr_idx   (free_slot_r),
    .rd_valid (rd_valid),
    .rd_mac   (rd_mac),
    .rd_addr  (rd_addr)
  );

  assign last_cmp  = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign cand_addr = host_addr(network_r, host_r);
  assign slot_ext  = 32'(slot_r);
  assign in_ready  = (state_r == S_IDLE);

  // Next state, table accesses and result load
  always_comb begin
    state_nxt      = state_r;
    mac_nxt        = mac_r;
    xid_nxt        = xid_r;
    reply_nxt      = reply_r;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    slot_nxt       = slot_r;
    free_slot_nxt  = free_slot_r;
    free_found_nxt = free_found_r;
    host_nxt       = host_r;
    tries_nxt      = tries_r;
    next_host_nxt  = next_host_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    rd_en          = 1'b0;
    wr.en          = 1'b0;
    wr.mac         = mac_r;
    wr.addr        = cand_addr;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_reply_nxt  = out_reply_r;
    out_addr_nxt   = out_addr_r;
    out_mask_nxt   = out_mask_r;
    out_xid_nxt    = out_xid_r;
    out_slot_nxt   = out_slot_r;

    // Issue table reads during either scan
    if (state_r == S_MSCAN || state_r == S_HSCAN) begin
      if (rd_idx_r < ENTRY_CNT) begin
        rd_en       = 1'b1;
        rd_idx_nxt  = rd_idx_r + CNTW'(1);
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_idx_r[IDXW-1:0];
      end else begin
        cmp_vld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mac_nxt        = in_client_mac;
          xid_nxt        = in_transaction_id;
          rd_idx_nxt     = '0;
          cmp_vld_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          priority if (in_message_type == MSG_DISCOVER) begin
            reply_nxt = REPLY_OFFER;
            state_nxt = S_MSCAN;
          end else if (in_message_type == MSG_REQUEST) begin
            reply_nxt = REPLY_ACK;
            state_nxt = S_MSCAN;
          end else begin
            status_nxt = STATUS_UNSUP;
            state_nxt  = S_DONE;
          end
        end
      end

      // Look for the MAC and note the first free slot
      S_MSCAN: begin
        if (cmp_vld_r) begin
          if (rd_valid && rd_mac == mac_r) begin
            slot_nxt   = cmp_idx_r;
            addr_nxt   = rd_addr;
            status_nxt = STATUS_OK;
            state_nxt  = S_DONE;
          end else begin
            if (!rd_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_slot_nxt  = cmp_idx_r;
            end
            if (last_cmp) begin
              if (free_found_r || !rd_valid) begin
                host_nxt    = pool_clamp(next_host_r);
                tries_nxt   = 8'd0;
                rd_idx_nxt  = '0;
                cmp_vld_nxt = 1'b0;
                state_nxt   = S_HSCAN;
              end else begin
                status_nxt = STATUS_FULL;
                state_nxt  = S_DONE;
              end
            end
          end
        end
      end

      // Test one candidate host against every lease; move on at a conflict
      S_HSCAN: begin
        if (cmp_vld_r) begin
          if (rd_valid && rd_addr == cand_addr) begin
            host_nxt  = pool_next(host_r);
            tries_nxt = tries_r + 8'd1;
            if (tries_r == POOL_SIZE - 8'd1) begin
              state_nxt = S_WRITE;
            end else begin
              rd_idx_nxt  = '0;
              cmp_vld_nxt = 1'b0;
            end
          end else if (last_cmp) begin
            state_nxt = S_WRITE;
          end
        end
      end

      // Store the new lease and advance the pointer
      S_WRITE: begin
        wr.en         = 1'b1;
        addr_nxt      = cand_addr;
        slot_nxt      = free_slot_r;
        next_host_nxt = pool_next(host_r);
        status_nxt    = STATUS_OK;
        state_nxt     = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_xid_nxt    = xid_r;
          if (status_r == STATUS_OK) begin
            out_reply_nxt = reply_r;
            out_addr_nxt  = addr_r;
            out_mask_nxt  = mask_of(prefix_r);
            out_slot_nxt  = slot_ext[4:0];
          end else begin
            out_reply_nxt = REPLY_NONE;
            out_addr_nxt  = 32'd0;
            out_mask_nxt  = 32'd0;
            out_slot_nxt  = 5'd0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_host_r  <= POOL_LOW;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_host_r  <= next_host_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mac_r        <= mac_nxt;
    xid_r        <= xid_nxt;
    reply_r      <= reply_nxt;
    status_r     <= status_nxt;
    addr_r       <= addr_nxt;
    slot_r       <= slot_nxt;
    free_slot_r  <= free_slot_nxt;
    host_r       <= host_nxt;
    tries_r      <= tries_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    out_status_r <= out_status_nxt;
    out_reply_r  <= out_reply_nxt;
    out_addr_r   <= out_addr_nxt;
    out_mask_r   <= out_mask_nxt;
    out_xid_r    <= out_xid_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_reply_type         = out_reply_r;
  assign out_leased_address     = out_addr_r;
  assign out_subnet_mask        = out_mask_r;
  assign out_echoed_transaction = out_xid_r;
  assign out_lease_slot         = out_slot_r;

endmodule

`default_nettype wire

// ----- rtl/dhcpl_tbl.sv -----
// Lease table storage: MAC and address memories plus per-entry valid bits.
`default_nettype none

module dhcpl_tbl
  import dhcpl_pkg::*;
#(
  parameter int unsigned LEASE_ENTRIES = DEFAULT_LEASE_ENTRIES,
  localparam int unsigned IDXW = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [IDXW-1:0] rd_idx,
  input  wire tbl_wr_t         wr,
  input  wire logic [IDXW-1:0] wr_idx,
  output logic                 rd_valid,
  output logic [47:0]          rd_mac,
  output logic [31:0]          rd_addr
);

  logic [47:0]              mac_mem  [LEASE_ENTRIES];
  logic [31:0]              addr_mem [LEASE_ENTRIES];
  logic [LEASE_ENTRIES-1:0] valid_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mac_mem[wr_idx]  <= wr.mac;
      addr_mem[wr_idx] <= wr.addr;
    end
    if (rd_en) begin
      rd_mac  <= mac_mem[rd_idx];
      rd_addr <= addr_mem[rd_idx];
    end
  end

  // Valid bits: cleared at reset, set on write, sampled with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid_r[rd_idx];
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the DHCP lease table engine: driver, monitor and lease predictor.
`timescale 1ns / 1ps

module tb
  import dhcpl_pkg::*;
;

  localparam int TBL_DEPTH   = DEFAULT_LEASE_ENTRIES;
  localparam int ITEMS_PHASE = 60;
  localparam int PHASES      = 9;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [47:0] mac;
    logic [7:0]  msg;
    logic [31:0] xid;
  } lease_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  reply;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] xid;
    logic [4:0]  slot;
  } lease_reply_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // Block ports
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [47:0] in_client_mac = '0;
  logic [7:0]  in_message_type = '0;
  logic [31:0] in_transaction_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_reply_type;
  logic [31:0] out_leased_address;
  logic [31:0] out_subnet_mask;
  logic [31:0] out_echoed_transaction;
  logic [4:0]  out_lease_slot;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dhcp_lease_table_engine_unit u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_client_mac          (in_client_mac),
    .in_message_type        (in_message_type),
    .in_transaction_id      (in_transaction_id),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_reply_type         (out_reply_type),
    .out_leased_address     (out_leased_address),
    .out_subnet_mask        (out_subnet_mask),
    .out_echoed_transaction (out_echoed_transaction),
    .out_lease_slot         (out_lease_slot),
    .cfg_psel               (cfg_psel),
    .cfg_penable            (cfg_penable),
    .cfg_pwrite             (cfg_pwrite),
    .cfg_paddr              (cfg_paddr),
    .cfg_pwdata             (cfg_pwdata),
    .cfg_prdata             (cfg_prdata),
    .cfg_pready             (cfg_pready)
  );

  // Lease table shadow and register copies
  logic [47:0] tbl_mac  [TBL_DEPTH];
  logic [31:0] tbl_addr [TBL_DEPTH];
  logic        tbl_used [TBL_DEPTH] = '{default: 1'b0};
  logic [7:0]  host_ptr   = POOL_LOW;
  logic [31:0] net_cfg    = NETWORK_RESET;
  logic [4:0]  prefix_cfg = PREFIX_RESET;

  // Stimulus and scoreboard storage
  lease_req_t   pending_reqs[$];
  lease_reply_t lease_expect[$];
  logic [47:0]  known_macs[$];
  lease_req_t   offered;
  lease_reply_t want;
  int           reqs_queued  = 0;
  int           replies_seen = 0;
  int           fails        = 0;
  int           tx_idle_pct  = 0;
  int           rx_stall_pct = 0;
  logic         rx_hold      = 1'b0;
  logic         press_go     = 1'b0;

  // Work out the reply to one request and update the lease table shadow
  function automatic lease_reply_t serve_request(input lease_req_t r);
    lease_reply_t rep;
    int           slot;
    int           free_slot;
    int           tries;
    logic [7:0]   host;
    logic [31:0]  cand;
    logic         clash;
    logic         found;
    rep = '0;
    rep.xid = r.xid;
    if (r.msg != MSG_DISCOVER && r.msg != MSG_REQUEST) begin
      rep.status = STATUS_UNSUP;
      return rep;
    end
    slot = -1;
    for (int i = 0; i < TBL_DEPTH; i++)
      if (slot < 0 && tbl_used[i] && tbl_mac[i] == r.mac) slot = i;
    if (slot < 0) begin
      free_slot = -1;
      for (int i = 0; i < TBL_DEPTH; i++)
        if (free_slot < 0 && !tbl_used[i]) free_slot = i;
      if (free_slot < 0) begin
        rep.status = STATUS_FULL;
        return rep;
      end
      // Search the pool from the rotating pointer, skipping hosts leased on this network
      host  = host_ptr;
      found = 1'b0;
      for (tries = 0; tries < POOL_SIZE && !found; tries++) begin
        if (host < POOL_LOW || host > POOL_HIGH) host = POOL_LOW;
        cand  = (net_cfg & HOST_NET_MASK) | {24'd0, host};
        clash = 1'b0;
        for (int j = 0; j < TBL_DEPTH; j++)
          if (tbl_used[j] && tbl_addr[j] == cand) clash = 1'b1;
        if (!clash) found = 1'b1;
        else host = (host >= POOL_HIGH) ? POOL_LOW : host + 8'd1;
      end
      tbl_mac[free_slot]  = r.mac;
      tbl_addr[free_slot] = (net_cfg & HOST_NET_MASK) | {24'd0, host};
      tbl_used[free_slot] = 1'b1;
      host_ptr = (host >= POOL_HIGH) ? POOL_LOW : host + 8'd1;
      slot = free_slot;
    end
    rep.status = STATUS_OK;
    rep.reply  = (r.msg == MSG_DISCOVER) ? REPLY_OFFER : REPLY_ACK;
    rep.addr   = tbl_addr[slot];
    rep.mask   = (prefix_cfg == 5'd0) ? 32'd0 : (32'hffff_ffff << (32 - prefix_cfg));
    rep.slot   = slot[4:0];
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got);
      fails++;
    end
  endtask

  task automatic queue_request(input logic [47:0] mac, input logic [7:0] msg,
                               input logic [31:0] xid);
    lease_req_t r;
    r.mac = mac;
    r.msg = msg;
    r.xid = xid;
    pending_reqs.push_back(r);
    known_macs.push_back(mac);
    reqs_queued++;
  endtask

  // Mostly well-formed requests on a growing set of clients, some noise types
  task automatic queue_random_request();
    logic [47:0] mac;
    logic [7:0]  msg;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 40) msg = MSG_DISCOVER;
    else if (pick < 80) msg = MSG_REQUEST;
    else msg = 8'($urandom_range(255));
    if (known_macs.size() == 0 || $urandom_range(99) < 9) begin
      mac[47:32] = 16'($urandom);
      mac[31:0]  = $urandom;
    end else begin
      mac = known_macs[$urandom_range(known_macs.size() - 1)];
    end
    queue_request(mac, msg, $urandom);
  endtask

  // Register write: setup beat, then access beat
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_NETWORK) net_cfg = value;
    else prefix_cfg = value[4:0];
  endtask

  task automatic set_config(input logic [31:0] net, input logic [4:0] prefix);
    write_reg(REG_NETWORK, net);
    write_reg(REG_PREFIX, {27'd0, prefix});
  endtask

  // Wait until every queued request has its reply back, then let the block settle
  task automatic wait_idle();
    while (replies_seen < reqs_queued) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) lease_expect.push_back(serve_request(offered));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered           <= pending_reqs[0];
          in_client_mac     <= pending_reqs[0].mac;
          in_message_type   <= pending_reqs[0].msg;
          in_transaction_id <= pending_reqs[0].xid;
          in_valid          <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply beat with the oldest prediction, drive back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (lease_expect.size() == 0) begin
          $error("reply beat with nothing predicted, xid %h", out_echoed_transaction);
          fails++;
        end else begin
          want = lease_expect.pop_front();
          check_field("status", want.status, out_status);
          check_field("reply_type", want.reply, out_reply_type);
          check_field("leased_address", want.addr, out_leased_address);
          check_field("subnet_mask", want.mask, out_subnet_mask);
          check_field("echoed_transaction", want.xid, out_echoed_transaction);
          check_field("lease_slot", want.slot, out_lease_slot);
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (press_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Stimulus sequence
  initial begin
    logic [31:0] net;
    logic [4:0]  prefix;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: new leases, renewals, unsupported types at reset settings
    queue_request(48'h0, MSG_DISCOVER, 32'h0);
    queue_request(48'h0, MSG_REQUEST, 32'hffff_ffff);
    queue_request(48'hffff_ffff_ffff, MSG_DISCOVER, 32'h1234_5678);
    queue_request(48'hffff_ffff_ffff, MSG_REQUEST, 32'h8000_0001);
    queue_request(48'h0012_3456_789a, MSG_REQUEST, 32'h0bad_f00d);
    queue_request(48'h0000_0000_0005, 8'd0, 32'h1111_1111);
    queue_request(48'h0, REPLY_OFFER, 32'h2222_2222);
    queue_request(48'hffff_ffff_ffff, 8'hff, 32'h3333_3333);
    queue_request(48'h0000_0000_0005, 8'd4, 32'h4444_4444);
    queue_request(48'h0000_0000_0005, MSG_DISCOVER, 32'h5555_5555);
    wait_idle();

    // Directed: network zero and prefix zero; an old lease keeps its address
    set_config(32'h0, 5'd0);
    queue_request(48'h0, MSG_REQUEST, 32'h6666_6666);
    queue_request(48'ha5a5_a5a5_a5a5, MSG_DISCOVER, 32'h7777_7777);
    wait_idle();

    // Directed: all-ones network with the longest mask
    set_config(32'hffff_ffff, 5'd31);
    queue_request(48'h5a5a_5a5a_5a5a, MSG_DISCOVER, 32'h8888_8888);
    queue_request(48'ha5a5_a5a5_a5a5, MSG_REQUEST, 32'h9999_9999);
    queue_request(48'h0012_3456_789a, MSG_DISCOVER, 32'haaaa_aaaa);
    wait_idle();

    // Random phases: vary settings and idling; the table fills part way through
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin net = 32'hffff_ffff; prefix = 5'd24; end
        1: begin net = 32'h0;         prefix = 5'd1;  end
        2: begin net = NETWORK_RESET; prefix = 5'd25; end
        default: begin net = $urandom; prefix = 5'($urandom_range(31)); end
      endcase
      set_config(net, prefix);
      case (p % 4)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 82; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 82; end
        default: begin tx_idle_pct <= 19; rx_stall_pct <= 19; end
      endcase
      for (int k = 0; k < ITEMS_PHASE; k++) queue_random_request();
      if (p == 4) press_go <= 1'b1;
      wait_idle();
    end

    if (fails == 0 && lease_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      if (lease_expect.size() != 0)
        $error("%0d predicted replies never arrived", lease_expect.size());
      $display("status: fail");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(40_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dhcpl_pkg.sv
rtl/dhcpl_tbl.sv
rtl/dhcp_lease_table_engine_unit.sv
verif/tb.sv
